// File: rtl/sclt_pkg.sv
// Shared types, character codes and helper functions for the command line tokenizer.
package sclt_pkg;

  localparam int LineBytesDefault = 32;
  localparam int MaxArgsDefault   = 5;

  // Configuration register indexes
  localparam logic CFG_DEVICE_ADDRESS = 1'b0;
  localparam logic CFG_DELIMITER_CHAR = 1'b1;

  // Reset values of the configuration registers
  localparam logic [7:0] DEVICE_ADDRESS_RST = 8'd48;
  localparam logic [7:0] DELIMITER_CHAR_RST = 8'd44;

  // Characters of interest
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_QUERY = 8'h3F;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  // Result kinds
  localparam logic KIND_TAG     = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Byte parts
  localparam logic [1:0] PART_ADDR = 2'd0;
  localparam logic [1:0] PART_CMD  = 2'd1;
  localparam logic [1:0] PART_SEP  = 2'd2;
  localparam logic [1:0] PART_ARG  = 2'd3;

  // Syntax error codes
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_CMD_CHAR   = 3'd1;
  localparam logic [2:0] ERR_CMD_LONG   = 3'd2;
  localparam logic [2:0] ERR_NO_ARG     = 3'd3;
  localparam logic [2:0] ERR_MANY_ARGS  = 3'd4;
  localparam logic [2:0] ERR_AFTER_DELIM = 3'd5;
  localparam logic [2:0] ERR_NO_ROOM    = 3'd6;
  localparam logic [2:0] ERR_ARG_END    = 3'd7;

  typedef enum logic [2:0] {
    PH_ADDR   = 3'd0,
    PH_CMD    = 3'd1,
    PH_SPACES = 3'd2,
    PH_ARG    = 3'd3,
    PH_DONE   = 3'd4,
    PH_DRAIN  = 3'd5
  } phase_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] tagged_byte;
    logic [1:0] part;
    logic [2:0] arg_index;
    logic       line_ok;
    logic [2:0] error_code;
    logic       address_match;
    logic [4:0] command_end;
    logic [2:0] argument_count;
    logic       final_of_input;
  } result_t;

  // Results produced by one accepted item, in order
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_alnum(logic [7:0] c);
    return is_alpha(c) || ((c >= 8'h30) && (c <= 8'h39));
  endfunction

  function automatic logic is_argch(logic [7:0] c);
    return is_alnum(c) || (c == CH_DASH);
  endfunction

endpackage

// File: rtl/sclt_parser.sv
// Line parser: per-line state and the tag and summary results for one accepted byte.
module sclt_parser #(
  parameter int LINE_BYTES = sclt_pkg::LineBytesDefault,
  parameter int MAX_ARGS   = sclt_pkg::MaxArgsDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      rx_byte_i,
  input  logic            chunk_end_i,
  input  logic [7:0]      device_address_i,
  input  logic [7:0]      delimiter_char_i,
  output sclt_pkg::push_t push_o
);
  import sclt_pkg::*;

  localparam int PW = $clog2(LINE_BYTES);
  localparam int AW = $clog2(MAX_ARGS + 2);

  localparam logic [PW-1:0] POS_ONE  = PW'(1);
  localparam logic [PW-1:0] POS_TWO  = PW'(2);
  localparam logic [PW-1:0] POS_THREE = PW'(3);
  localparam logic [PW-1:0] POS_LAST = PW'(LINE_BYTES - 1);
  localparam logic [PW-1:0] POS_ROOM = PW'(LINE_BYTES - 2);
  localparam logic [AW-1:0] ARGS_MAX = AW'(MAX_ARGS);

  typedef struct packed {
    phase_e        phase;
    logic [PW-1:0] pos;
    logic [2:0]    err;
    logic [AW-1:0] args;
    logic [PW-1:0] cend;
    logic          slash;
    logic          hit;
    logic          pend;
  } st_t;

  localparam st_t ST_CLEAR = '{phase: PH_ADDR, pos: '0, err: ERR_NONE, args: '0,
                               cend: '0, slash: 1'b0, hit: 1'b0, pend: 1'b0};

  function automatic st_t fail_st(st_t s, logic [2:0] code);
    st_t r;
    r = s;
    if (r.err == ERR_NONE) r.err = code;
    r.phase = PH_DONE;
    return r;
  endfunction

  function automatic result_t summarize(st_t s, logic [7:0] dev);
    result_t       r;
    logic [2:0]    err;
    logic [PW-1:0] cend;
    logic [2:0]    cnt;
    r    = '0;
    err  = s.err;
    cend = '0;
    cnt  = '0;
    unique case (s.phase)
      PH_ADDR: cend = POS_TWO;
      PH_CMD: begin
        if (s.pos >= POS_LAST) begin
          if (err == ERR_NONE) err = ERR_CMD_LONG;
        end else begin
          cend = s.pos;
        end
      end
      PH_SPACES: begin
        if (err == ERR_NONE) err = ERR_NO_ARG;
      end
      PH_ARG: begin
        if (s.pend) begin
          if (err == ERR_NONE) err = ERR_AFTER_DELIM;
        end else begin
          cend = s.cend;
          cnt  = 3'(s.args + AW'(1));
        end
      end
      default: begin
        if (err == ERR_NONE) begin
          cend = s.cend;
          cnt  = 3'(s.args);
        end
      end
    endcase
    if (err != ERR_NONE) begin
      cend = '0;
      cnt  = '0;
    end
    r.kind           = KIND_SUMMARY;
    r.line_ok        = (err == ERR_NONE);
    r.error_code     = err;
    r.address_match  = s.slash && ((s.pos >= POS_TWO) ? s.hit : (dev == 8'd0));
    r.command_end    = 5'(cend);
    r.argument_count = cnt;
    r.final_of_input = 1'b1;
    return r;
  endfunction

  st_t           st_q, st_d;
  st_t           tag_st;
  st_t           after_st;
  logic [1:0]    tag_part;
  logic [AW-1:0] tag_idx;
  logic          enter_arg;
  logic          is_term;
  logic          kept;
  result_t       tag_res;

  // Effect of one kept byte on the line state
  always_comb begin
    tag_st    = st_q;
    tag_part  = PART_SEP;
    tag_idx   = '0;
    enter_arg = 1'b0;
    if (st_q.pos == '0) begin
      tag_st.slash = (rx_byte_i == CH_SLASH);
      tag_part     = PART_ADDR;
    end else if (st_q.pos == POS_ONE) begin
      tag_st.hit   = (rx_byte_i == device_address_i);
      tag_st.phase = PH_CMD;
      tag_part     = PART_ADDR;
    end else begin
      unique case (st_q.phase)
        PH_CMD: begin
          if ((rx_byte_i == CH_NUL) || is_space(rx_byte_i)) begin
            tag_st.cend  = st_q.pos;
            tag_st.phase = (rx_byte_i == CH_NUL) ? PH_DONE : PH_SPACES;
          end else if (((st_q.pos == POS_TWO) && (rx_byte_i == CH_SLASH)) ||
                       ((st_q.pos == POS_THREE) && is_alpha(rx_byte_i)) ||
                       ((st_q.pos > POS_THREE) &&
                        (is_alnum(rx_byte_i) || (rx_byte_i == CH_QUERY)))) begin
            tag_part = PART_CMD;
          end else begin
            tag_st = fail_st(st_q, ERR_CMD_CHAR);
          end
        end
        PH_SPACES: begin
          if (rx_byte_i == CH_NUL) begin
            tag_st = fail_st(st_q, ERR_NO_ARG);
          end else if (!is_space(rx_byte_i)) begin
            tag_st.phase = PH_ARG;
            tag_st.args  = '0;
            tag_st.pend  = 1'b0;
            enter_arg    = 1'b1;
          end
        end
        default: ;
      endcase
      if ((st_q.phase == PH_ARG) || enter_arg) begin
        if (tag_st.pend) begin
          if (!is_argch(rx_byte_i)) begin
            tag_st = fail_st(tag_st, ERR_AFTER_DELIM);
          end else if (tag_st.args >= ARGS_MAX) begin
            tag_st = fail_st(tag_st, ERR_MANY_ARGS);
          end else begin
            tag_st.pend = 1'b0;
            tag_idx     = tag_st.args;
            tag_part    = PART_ARG;
          end
        end else if (is_argch(rx_byte_i)) begin
          tag_idx  = tag_st.args;
          tag_part = PART_ARG;
        end else if ((rx_byte_i != CH_NUL) && (rx_byte_i == delimiter_char_i)) begin
          if (st_q.pos >= POS_ROOM) begin
            tag_st = fail_st(tag_st, ERR_NO_ROOM);
          end else begin
            tag_st.args = tag_st.args + AW'(1);
            tag_st.pend = 1'b1;
          end
        end else if (rx_byte_i == CH_NUL) begin
          tag_st.args  = tag_st.args + AW'(1);
          tag_st.phase = PH_DONE;
        end else begin
          tag_st = fail_st(tag_st, ERR_ARG_END);
        end
      end
    end
    tag_st.pos = st_q.pos + POS_ONE;
  end

  always_comb begin
    tag_res                = '0;
    tag_res.kind           = KIND_TAG;
    tag_res.tagged_byte    = rx_byte_i;
    tag_res.part           = tag_part;
    tag_res.arg_index      = 3'(tag_idx);
    tag_res.final_of_input = !chunk_end_i;
  end

  assign is_term  = (rx_byte_i == CH_CR) || (rx_byte_i == CH_LF);
  assign kept     = (st_q.pos < POS_LAST);
  assign after_st = kept ? tag_st : st_q;

  always_comb begin
    st_d   = st_q;
    push_o = '0;
    if (accept_i) begin
      if (st_q.phase == PH_DRAIN) begin
        if (chunk_end_i) st_d = ST_CLEAR;
      end else if (is_term) begin
        push_o.count = 2'd1;
        push_o.first = summarize(st_q, device_address_i);
        st_d         = ST_CLEAR;
        if (!chunk_end_i) st_d.phase = PH_DRAIN;
      end else begin
        push_o.second = summarize(after_st, device_address_i);
        if (kept) begin
          push_o.first = tag_res;
          push_o.count = chunk_end_i ? 2'd2 : 2'd1;
        end else begin
          push_o.first = push_o.second;
          push_o.count = chunk_end_i ? 2'd1 : 2'd0;
        end
        st_d = chunk_end_i ? ST_CLEAR : after_st;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_CLEAR;
    end else begin
      st_q <= st_d;
    end
  end

endmodule

// File: rtl/serial_command_line_tokenizer_unit.sv
// Top level of the serial command line tokenizer: configuration, parser and result queue.
//
// Received bytes of a command line such as "/0/pwm 252,7" enter on the s_axis channel, one
// byte per item, with tlast marking the last byte of a received chunk. Each kept byte
// leaves on the m_axis channel as a tag item (tuser = 0) naming it address prefix, command,
// separator or argument, with its argument index. When the line closes, at the first CR or
// LF or at the end of a chunk, a summary item (tuser = 1) follows with the address match,
// the command end position, the argument count and the first syntax error. m_axis tlast
// marks the last item caused by one input byte.
// The device address and the delimiter are written through the cfg port; the user must write
// them only while the block is idle, which the block does not enforce; register 0 is the
// device address and register 1 the delimiter character. Each result is registered in a
// four-entry queue; s_axis_tready is low while it holds more than two, so a stalled
// receiver backs up into the sender without losing or repeating anything. The parser
// takes one byte every cycle while s_axis_tready is high; the output side moves one
// result a cycle while m_axis_tready is high. A byte that closes a chunk and also yields
// a tag pushes two results. Reset empties the queue, starts a fresh line and restores the
// configuration defaults (device address 48, delimiter 44); no clearing pass is needed.
module serial_command_line_tokenizer_unit #(
  parameter int LINE_BYTES = sclt_pkg::LineBytesDefault,
  parameter int MAX_ARGS   = sclt_pkg::MaxArgsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input bytes
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tlast,   // chunk_end
  // Results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] tagged_byte, [9:8] part, [12:10] arg_index, [13] line_ok,
  // [16:14] error_code, [17] address_match, [22:18] command_end,
  // [25:23] argument_count, [31:26] zero
  output logic [31:0] m_axis_tdata,
  output logic [0:0]  m_axis_tuser,   // [0] result_kind
  output logic        m_axis_tlast,   // final_of_input
  // Configuration writes
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i
);
  import sclt_pkg::*;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  logic [7:0] dev_addr_q, delim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= DEVICE_ADDRESS_RST;
      delim_q    <= DELIMITER_CHAR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_DEVICE_ADDRESS: dev_addr_q <= cfg_data_i;
        CFG_DELIMITER_CHAR: delim_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic  in_acc;
  push_t push;

  assign in_acc = s_axis_tvalid && s_axis_tready;

  sclt_parser #(
    .LINE_BYTES(LINE_BYTES),
    .MAX_ARGS  (MAX_ARGS)
  ) u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (in_acc),
    .rx_byte_i       (s_axis_tdata),
    .chunk_end_i     (s_axis_tlast),
    .device_address_i(dev_addr_q),
    .delimiter_char_i(delim_q),
    .push_o          (push)
  );

  // Result queue: up to two entries written per cycle, one read
  result_t            q_mem [QDEPTH];
  logic [QAW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [QCW-1:0]     cnt_q, cnt_d;
  logic               out_pop;
  result_t            head;

  assign out_pop       = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (cnt_q <= QCW'(QDEPTH - 2));
  assign m_axis_tvalid = (cnt_q != '0);

  always_ff @(posedge clk_i) begin
    if (push.count != 2'd0) q_mem[wr_q] <= push.first;
    if (push.count == 2'd2) q_mem[wr_q + QAW'(1)] <= push.second;
  end

  always_comb begin
    wr_d  = wr_q + QAW'(push.count);
    rd_d  = rd_q + QAW'(out_pop);
    cnt_d = cnt_q + QCW'(push.count) - QCW'(out_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  assign head = q_mem[rd_q];

  assign m_axis_tdata = {6'd0, head.argument_count, head.command_end, head.address_match,
                         head.error_code, head.line_ok, head.arg_index, head.part,
                         head.tagged_byte};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.final_of_input;

  // The queue never overfills
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= QCW'(QDEPTH))
    else $error("result queue overfilled");

  // Pointer distance and fill count agree
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    QAW'(wr_q - rd_q) == QAW'(cnt_q))
    else $error("queue pointers out of step with fill count");

  // No results appear without an accepted byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_acc |-> (push.count == 2'd0))
    else $error("results pushed without an accepted item");

  // A summary is always the last result of its byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (head.kind == KIND_SUMMARY)) |-> head.final_of_input)
    else $error("summary item without final mark");

  // A summary with an error reports no command end and no arguments
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (head.kind == KIND_SUMMARY) && (head.error_code != ERR_NONE))
      |-> (!head.line_ok && (head.command_end == 5'd0) && (head.argument_count == 3'd0)))
    else $error("error summary carries command fields");

endmodule
